>>> hdl/pl0_lex_pkg.sv
`timescale 1ns / 1ps

package pl0_lex_pkg;

   localparam int NUM_W = 17;
   localparam int KW_COUNT = 14;
   localparam int KW_MAX_LEN = 9;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [5:0] TOK_ERROR   = 6'd0;
   localparam logic [5:0] TOK_IDENT   = 6'd2;
   localparam logic [5:0] TOK_NUMBER  = 6'd3;
   localparam logic [5:0] TOK_PLUS    = 6'd4;
   localparam logic [5:0] TOK_MINUS   = 6'd5;
   localparam logic [5:0] TOK_TIMES   = 6'd6;
   localparam logic [5:0] TOK_SLASH   = 6'd7;
   localparam logic [5:0] TOK_IFEL    = 6'd8;
   localparam logic [5:0] TOK_EQL     = 6'd9;
   localparam logic [5:0] TOK_NEQ     = 6'd10;
   localparam logic [5:0] TOK_LSS     = 6'd11;
   localparam logic [5:0] TOK_LEQ     = 6'd12;
   localparam logic [5:0] TOK_GTR     = 6'd13;
   localparam logic [5:0] TOK_GEQ     = 6'd14;
   localparam logic [5:0] TOK_LPAREN  = 6'd15;
   localparam logic [5:0] TOK_RPAREN  = 6'd16;
   localparam logic [5:0] TOK_COMMA   = 6'd17;
   localparam logic [5:0] TOK_SEMI    = 6'd18;
   localparam logic [5:0] TOK_PERIOD  = 6'd19;
   localparam logic [5:0] TOK_BECOMES = 6'd20;
   localparam logic [5:0] TOK_BEGIN   = 6'd21;
   localparam logic [5:0] TOK_END     = 6'd22;
   localparam logic [5:0] TOK_IF      = 6'd23;
   localparam logic [5:0] TOK_THEN    = 6'd24;
   localparam logic [5:0] TOK_WHILE   = 6'd25;
   localparam logic [5:0] TOK_DO      = 6'd26;
   localparam logic [5:0] TOK_CALL    = 6'd27;
   localparam logic [5:0] TOK_CONST   = 6'd28;
   localparam logic [5:0] TOK_VAR     = 6'd29;
   localparam logic [5:0] TOK_PROC    = 6'd30;
   localparam logic [5:0] TOK_WRITE   = 6'd31;
   localparam logic [5:0] TOK_READ    = 6'd32;
   localparam logic [5:0] TOK_ELSE    = 6'd33;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_IDENT_LONG = 3'd1;
   localparam logic [2:0] ERR_NUM_LONG   = 3'd2;
   localparam logic [2:0] ERR_COLON      = 3'd3;
   localparam logic [2:0] ERR_INVALID    = 3'd4;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_PERIOD = 8'h2E;

   // Keyword text is right-justified: the first character of a keyword of
   // length L sits in bits (L-1)*8 upwards.
   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
      "const", "var", "procedure", "call", "begin", "end", "if",
      "then", "while", "do", "read", "write", "ifel", "else"
   };
   localparam int KW_LEN [KW_COUNT] = '{5, 3, 9, 4, 5, 3, 2, 4, 5, 2, 4, 5, 4, 4};
   localparam logic [5:0] KW_CODE [KW_COUNT] = '{
      TOK_CONST, TOK_VAR, TOK_PROC, TOK_CALL, TOK_BEGIN, TOK_END, TOK_IF,
      TOK_THEN, TOK_WHILE, TOK_DO, TOK_READ, TOK_WRITE, TOK_IFEL, TOK_ELSE
   };

   typedef struct packed {
      logic       cmd;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [5:0]       token_class;
      logic [2:0]       error_code;
      logic [NUM_W-1:0] number_value;
      logic [7:0]       text_char;
      logic             last;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_WORD_LONG,
      MODE_NUM,
      MODE_LT,
      MODE_GT,
      MODE_EQ,
      MODE_COLON,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_COMMENT_STAR
   } scan_mode_type;

   typedef enum logic [2:0] {
      DEC_ABSORB,
      DEC_PAIR,
      DEC_FLUSH,
      DEC_FRESH,
      DEC_DONE
   } dec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH,
      ST_FRESH
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic absorb;
      logic emit_pair;
      logic set_idle;
      logic flush_emit;
      logic flush_done;
      logic fresh;
   } dp_cmd_type;

   typedef struct packed {
      dec_type dec;
      logic    end_of_text;
      logic    run_mode;
      logic    run_last;
      logic    fresh_emits;
      logic    out_free;
   } dp_status_type;

endpackage

>>> hdl/pl0_lex_ctrl.sv
`timescale 1ns / 1ps

module pl0_lex_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pl0_lex_pkg::dp_status_type dp_status,
   output pl0_lex_pkg::dp_cmd_type    dp_cmd
);
   import pl0_lex_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           flush_finish;

   assign flush_finish = dp_status.out_free && (!dp_status.run_mode || dp_status.run_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            case (dp_status.dec)
               DEC_ABSORB: state_in = ST_IDLE;
               DEC_PAIR: begin
                  if (dp_status.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               DEC_FLUSH: state_in = ST_FLUSH;
               DEC_FRESH: state_in = ST_FRESH;
               DEC_DONE:  state_in = ST_IDLE;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_FLUSH: begin
            if (flush_finish) begin
               state_in = dp_status.end_of_text ? ST_IDLE : ST_FRESH;
            end
         end
         ST_FRESH: begin
            if (!dp_status.fresh_emits || dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready          = (state_ff == ST_IDLE);
      dp_cmd             = '0;
      dp_cmd.take        = (state_ff == ST_IDLE) && req_valid;
      dp_cmd.absorb      = (state_ff == ST_STEP) && (dp_status.dec == DEC_ABSORB);
      dp_cmd.emit_pair   = (state_ff == ST_STEP) && (dp_status.dec == DEC_PAIR)
                           && dp_status.out_free;
      dp_cmd.set_idle    = (state_ff == ST_STEP) && (dp_status.dec == DEC_DONE);
      dp_cmd.flush_emit  = (state_ff == ST_FLUSH) && dp_status.out_free;
      dp_cmd.flush_done  = (state_ff == ST_FLUSH) && flush_finish;
      dp_cmd.fresh       = (state_ff == ST_FRESH)
                           && (!dp_status.fresh_emits || dp_status.out_free);
   end

endmodule

>>> hdl/pl0_lex_dp.sv
`timescale 1ns / 1ps

module pl0_lex_dp #(
   parameter int MAX_IDENT_LEN  = 11,
   parameter int MAX_NUM_DIGITS = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pl0_lex_pkg::req_type       req_data,
   input  pl0_lex_pkg::dp_cmd_type    dp_cmd,
   output pl0_lex_pkg::dp_status_type dp_status,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pl0_lex_pkg::rsp_type       rsp_data
);
   import pl0_lex_pkg::*;

   localparam int IDX_W = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;
   localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1);
   localparam int CNT_W = $clog2(MAX_NUM_DIGITS + 2);
   localparam int ACC_W = $clog2(10 ** MAX_NUM_DIGITS);

   logic             cmd_ff;
   logic [7:0]       char_ff;
   scan_mode_type    mode_ff;
   scan_mode_type    mode_in;
   logic [7:0]       buf_ff [MAX_IDENT_LEN];
   logic             buf_we;
   logic [IDX_W-1:0] buf_wa;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             is_letter;
   logic             is_digit;
   logic             is_skip;
   logic [3:0]       digit_val;
   logic             kw_hit;
   logic [5:0]       kw_code;
   logic             kw_char_ok;
   logic             run_last;
   logic             fresh_emits;
   logic             out_free;
   rsp_type          pair_tok;
   rsp_type          flush_tok;
   rsp_type          fresh_tok;
   dec_type          dec;

   assign is_letter = ((char_ff >= 8'h61) && (char_ff <= 8'h7A))
                      || ((char_ff >= 8'h41) && (char_ff <= 8'h5A));
   assign is_digit  = (char_ff >= 8'h30) && (char_ff <= 8'h39);
   assign is_skip   = (char_ff < CH_SPACE) || (char_ff == CH_DEL) || (char_ff == CH_SPACE);
   assign digit_val = char_ff[3:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign run_last  = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

   assign fresh_emits = !is_skip && !is_letter && !is_digit
                        && (char_ff != CH_LT) && (char_ff != CH_GT) && (char_ff != CH_EQ)
                        && (char_ff != CH_COLON) && (char_ff != CH_SLASH);

   always_comb begin
      dec = DEC_FRESH;
      if (cmd_ff == CMD_END) begin
         if ((mode_ff == MODE_IDLE) || (mode_ff == MODE_COMMENT)
             || (mode_ff == MODE_COMMENT_STAR)) begin
            dec = DEC_DONE;
         end else begin
            dec = DEC_FLUSH;
         end
      end else begin
         case (mode_ff)
            MODE_IDLE:      dec = DEC_FRESH;
            MODE_WORD:      dec = (is_letter || is_digit) ? DEC_ABSORB : DEC_FLUSH;
            MODE_WORD_LONG: dec = (is_letter || is_digit) ? DEC_ABSORB : DEC_FLUSH;
            MODE_NUM:       dec = is_digit ? DEC_ABSORB : DEC_FLUSH;
            MODE_LT: begin
               dec = ((char_ff == CH_EQ) || (char_ff == CH_GT)) ? DEC_PAIR : DEC_FLUSH;
            end
            MODE_GT: begin
               dec = ((char_ff == CH_EQ) || (char_ff == CH_LT)) ? DEC_PAIR : DEC_FLUSH;
            end
            MODE_EQ:           dec = (char_ff == CH_EQ) ? DEC_PAIR : DEC_FLUSH;
            MODE_COLON:        dec = (char_ff == CH_EQ) ? DEC_PAIR : DEC_FLUSH;
            MODE_SLASH:        dec = (char_ff == CH_STAR) ? DEC_ABSORB : DEC_FLUSH;
            MODE_COMMENT:      dec = DEC_ABSORB;
            MODE_COMMENT_STAR: dec = DEC_ABSORB;
            default:           dec = DEC_FRESH;
         endcase
      end
   end

   always_comb begin
      kw_hit  = 1'b0;
      kw_code = TOK_ERROR;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_char_ok = (KW_LEN[k] <= MAX_IDENT_LEN) && (len_ff == LEN_W'(KW_LEN[k]));
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if ((j < KW_LEN[k]) && (j < MAX_IDENT_LEN)) begin
               if (buf_ff[IDX_W'(j)] != KW_TEXT[k][(KW_LEN[k] - 1 - j) * 8 +: 8]) begin
                  kw_char_ok = 1'b0;
               end
            end
         end
         if (kw_char_ok && !kw_hit) begin
            kw_hit  = 1'b1;
            kw_code = KW_CODE[k];
         end
      end
   end

   always_comb begin
      dp_status             = '0;
      dp_status.dec         = dec;
      dp_status.end_of_text = (cmd_ff == CMD_END);
      dp_status.run_mode    = (mode_ff == MODE_WORD) && !kw_hit;
      dp_status.run_last    = run_last;
      dp_status.fresh_emits = fresh_emits;
      dp_status.out_free    = out_free;
   end

   always_comb begin
      pair_tok      = '0;
      pair_tok.last = 1'b1;
      case (mode_ff)
         MODE_LT:    pair_tok.token_class = (char_ff == CH_EQ) ? TOK_LEQ : TOK_NEQ;
         MODE_GT:    pair_tok.token_class = (char_ff == CH_EQ) ? TOK_GEQ : TOK_NEQ;
         MODE_EQ:    pair_tok.token_class = TOK_EQL;
         MODE_COLON: pair_tok.token_class = TOK_BECOMES;
         default:    pair_tok.token_class = TOK_ERROR;
      endcase
   end

   always_comb begin
      flush_tok      = '0;
      flush_tok.last = 1'b1;
      case (mode_ff)
         MODE_WORD: begin
            if (kw_hit) begin
               flush_tok.token_class = kw_code;
            end else begin
               flush_tok.token_class = TOK_IDENT;
               flush_tok.text_char   = buf_ff[idx_ff];
               flush_tok.last        = run_last;
            end
         end
         MODE_WORD_LONG: flush_tok.error_code = ERR_IDENT_LONG;
         MODE_NUM: begin
            if (cnt_ff > CNT_W'(MAX_NUM_DIGITS)) begin
               flush_tok.error_code = ERR_NUM_LONG;
            end else begin
               flush_tok.token_class  = TOK_NUMBER;
               flush_tok.number_value = NUM_W'(acc_ff);
            end
         end
         MODE_LT:    flush_tok.token_class = TOK_LSS;
         MODE_GT:    flush_tok.token_class = TOK_GTR;
         MODE_EQ:    flush_tok.token_class = TOK_EQL;
         MODE_COLON: flush_tok.error_code  = ERR_COLON;
         MODE_SLASH: flush_tok.token_class = TOK_SLASH;
         default:    flush_tok.token_class = TOK_ERROR;
      endcase
   end

   always_comb begin
      fresh_tok      = '0;
      fresh_tok.last = 1'b1;
      case (char_ff)
         CH_PLUS:   fresh_tok.token_class = TOK_PLUS;
         CH_MINUS:  fresh_tok.token_class = TOK_MINUS;
         CH_STAR:   fresh_tok.token_class = TOK_TIMES;
         CH_LPAREN: fresh_tok.token_class = TOK_LPAREN;
         CH_RPAREN: fresh_tok.token_class = TOK_RPAREN;
         CH_COMMA:  fresh_tok.token_class = TOK_COMMA;
         CH_SEMI:   fresh_tok.token_class = TOK_SEMI;
         CH_PERIOD: fresh_tok.token_class = TOK_PERIOD;
         default:   fresh_tok.error_code  = ERR_INVALID;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      buf_we  = 1'b0;
      buf_wa  = len_ff[IDX_W-1:0];
      if (dp_cmd.absorb) begin
         case (mode_ff)
            MODE_WORD: begin
               if (len_ff < LEN_W'(MAX_IDENT_LEN)) begin
                  buf_we = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end else begin
                  mode_in = MODE_WORD_LONG;
               end
            end
            MODE_NUM: begin
               if (cnt_ff < CNT_W'(MAX_NUM_DIGITS)) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + ACC_W'(digit_val);
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  cnt_in = CNT_W'(MAX_NUM_DIGITS + 1);
               end
            end
            MODE_SLASH: mode_in = MODE_COMMENT;
            MODE_COMMENT: begin
               if (char_ff == CH_STAR) begin
                  mode_in = MODE_COMMENT_STAR;
               end
            end
            MODE_COMMENT_STAR: begin
               if (char_ff == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (char_ff != CH_STAR) begin
                  mode_in = MODE_COMMENT;
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
      if (dp_cmd.emit_pair || dp_cmd.set_idle) begin
         mode_in = MODE_IDLE;
      end
      if (dp_cmd.flush_emit && (mode_ff == MODE_WORD) && !kw_hit && !run_last) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (dp_cmd.flush_done) begin
         mode_in = MODE_IDLE;
         idx_in  = '0;
      end
      if (dp_cmd.fresh) begin
         mode_in = MODE_IDLE;
         if (is_letter) begin
            buf_we  = 1'b1;
            buf_wa  = '0;
            len_in  = LEN_W'(1);
            mode_in = MODE_WORD;
         end else if (is_digit) begin
            acc_in  = ACC_W'(digit_val);
            cnt_in  = CNT_W'(1);
            mode_in = MODE_NUM;
         end else begin
            case (char_ff)
               CH_LT:    mode_in = MODE_LT;
               CH_GT:    mode_in = MODE_GT;
               CH_EQ:    mode_in = MODE_EQ;
               CH_COLON: mode_in = MODE_COLON;
               CH_SLASH: mode_in = MODE_SLASH;
               default:  mode_in = MODE_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (dp_cmd.emit_pair) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pair_tok;
      end else if (dp_cmd.flush_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = flush_tok;
      end else if (dp_cmd.fresh && fresh_emits) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fresh_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         len_ff       <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.take) begin
         cmd_ff  <= req_data.cmd;
         char_ff <= req_data.char_code;
      end
      if (buf_we) begin
         buf_ff[buf_wa] <= char_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/pl0_lexical_tokenizer_top.sv
// A beat is captured in the idle state and decided in the step state. A closing pair is
// emitted from the step state; a flushed token from the flush state, one result beat per
// identifier character, then a new single-character token from the fresh state, which is
// skipped at end of text. Results are registered, each emission waits for the output to be
// free, and no new beat is taken until the one in hand is finished.
// Reset is synchronous and active high; it returns the scanner to idle and drops any result.
`timescale 1ns / 1ps

module pl0_lexical_tokenizer_top #(
   parameter int MAX_IDENT_LEN  = 11,
   parameter int MAX_NUM_DIGITS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pl0_lex_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pl0_lex_pkg::rsp_type rsp_data
);
   import pl0_lex_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   pl0_lex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   pl0_lex_dp #(
      .MAX_IDENT_LEN  (MAX_IDENT_LEN),
      .MAX_NUM_DIGITS (MAX_NUM_DIGITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/pl0_lex_checker.sv
`timescale 1ns / 1ps

module pl0_lex_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input pl0_lex_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pl0_lex_pkg::rsp_type rsp_data
);
   import pl0_lex_pkg::*;

   // A result beat that is not taken must stay put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The scanner works on one character at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.error_code != ERR_NONE) == (rsp_data.token_class == TOK_ERROR)))
      else $error("error code and token class disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.token_class != TOK_IDENT)
      |-> rsp_data.last && (rsp_data.text_char == 8'd0))
      else $error("non-identifier token spans several beats");

endmodule

bind pl0_lexical_tokenizer_top pl0_lex_checker u_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pl0_lex_pkg::*;

   localparam int IDENT_LIMIT   = 11;
   localparam int DIGIT_LIMIT   = 5;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   scan_mode_type lex_mode = MODE_IDLE;
   logic [7:0]    word_chars [IDENT_LIMIT];
   int unsigned   word_len = 0;
   int unsigned   num_value = 0;
   int unsigned   num_digits = 0;
   rsp_type       pending_tokens [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_request = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;
   int failures = 0;
   int beats_sent = 0;
   int tokens_checked = 0;

   string keywords [14] = '{"const", "var", "procedure", "call", "begin", "end", "if",
                            "then", "while", "do", "read", "write", "ifel", "else"};
   string operators [19] = '{"+", "-", "*", "/", "(", ")", ",", ";", ".", ":=", "<=",
                             ">=", "<>", "><", "==", "=", "<", ">", ":"};
   string comment_fill = "a*/ 9";

   pl0_lexical_tokenizer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] word_class();
      logic [8*IDENT_LIMIT-1:0] packed_word;
      packed_word = '0;
      for (int i = 0; i < word_len; i++) begin
         packed_word = {packed_word[8*IDENT_LIMIT-9:0], word_chars[i]};
      end
      case (packed_word)
         "const": return TOK_CONST;
         "var": return TOK_VAR;
         "procedure": return TOK_PROC;
         "call": return TOK_CALL;
         "begin": return TOK_BEGIN;
         "end": return TOK_END;
         "if": return TOK_IF;
         "then": return TOK_THEN;
         "while": return TOK_WHILE;
         "do": return TOK_DO;
         "read": return TOK_READ;
         "write": return TOK_WRITE;
         "ifel": return TOK_IFEL;
         "else": return TOK_ELSE;
         default: return TOK_IDENT;
      endcase
   endfunction

   function automatic void push_token(input logic [5:0] cls, input logic [2:0] err,
                                      input logic [NUM_W-1:0] val, input logic [7:0] ch,
                                      input logic last);
      rsp_type t;
      t.token_class  = cls;
      t.error_code   = err;
      t.number_value = val;
      t.text_char    = ch;
      t.last         = last;
      pending_tokens.push_back(t);
   endfunction

   function automatic void flush_pending();
      logic [5:0] code;
      case (lex_mode)
         MODE_WORD: begin
            code = word_class();
            if (code != TOK_IDENT) begin
               push_token(code, ERR_NONE, '0, 8'h00, 1'b1);
            end else begin
               for (int i = 0; i < word_len; i++) begin
                  push_token(TOK_IDENT, ERR_NONE, '0, word_chars[i], i == word_len - 1);
               end
            end
         end
         MODE_WORD_LONG: push_token(TOK_ERROR, ERR_IDENT_LONG, '0, 8'h00, 1'b1);
         MODE_NUM: begin
            if (num_digits > DIGIT_LIMIT) begin
               push_token(TOK_ERROR, ERR_NUM_LONG, '0, 8'h00, 1'b1);
            end else begin
               push_token(TOK_NUMBER, ERR_NONE, num_value[NUM_W-1:0], 8'h00, 1'b1);
            end
         end
         MODE_LT: push_token(TOK_LSS, ERR_NONE, '0, 8'h00, 1'b1);
         MODE_GT: push_token(TOK_GTR, ERR_NONE, '0, 8'h00, 1'b1);
         MODE_EQ: push_token(TOK_EQL, ERR_NONE, '0, 8'h00, 1'b1);
         MODE_COLON: push_token(TOK_ERROR, ERR_COLON, '0, 8'h00, 1'b1);
         MODE_SLASH: push_token(TOK_SLASH, ERR_NONE, '0, 8'h00, 1'b1);
         default: ;
      endcase
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void start_token(input logic [7:0] c);
      if (c <= CH_SPACE || c == CH_DEL) return;
      if (is_letter(c)) begin
         word_chars[0] = c;
         word_len = 1;
         lex_mode = MODE_WORD;
         return;
      end
      if (is_digit(c)) begin
         num_value = c - "0";
         num_digits = 1;
         lex_mode = MODE_NUM;
         return;
      end
      case (c)
         CH_LT: lex_mode = MODE_LT;
         CH_GT: lex_mode = MODE_GT;
         CH_EQ: lex_mode = MODE_EQ;
         CH_COLON: lex_mode = MODE_COLON;
         CH_SLASH: lex_mode = MODE_SLASH;
         CH_PLUS: push_token(TOK_PLUS, ERR_NONE, '0, 8'h00, 1'b1);
         CH_MINUS: push_token(TOK_MINUS, ERR_NONE, '0, 8'h00, 1'b1);
         CH_STAR: push_token(TOK_TIMES, ERR_NONE, '0, 8'h00, 1'b1);
         CH_LPAREN: push_token(TOK_LPAREN, ERR_NONE, '0, 8'h00, 1'b1);
         CH_RPAREN: push_token(TOK_RPAREN, ERR_NONE, '0, 8'h00, 1'b1);
         CH_COMMA: push_token(TOK_COMMA, ERR_NONE, '0, 8'h00, 1'b1);
         CH_SEMI: push_token(TOK_SEMI, ERR_NONE, '0, 8'h00, 1'b1);
         CH_PERIOD: push_token(TOK_PERIOD, ERR_NONE, '0, 8'h00, 1'b1);
         default: push_token(TOK_ERROR, ERR_INVALID, '0, 8'h00, 1'b1);
      endcase
   endfunction

   function automatic void lex_beat(input req_type item);
      logic [7:0] c;
      c = item.char_code;
      if (item.cmd == CMD_END) begin
         if (lex_mode == MODE_COMMENT || lex_mode == MODE_COMMENT_STAR) lex_mode = MODE_IDLE;
         flush_pending();
         return;
      end
      case (lex_mode)
         MODE_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
               if (word_len < IDENT_LIMIT) begin
                  word_chars[word_len] = c;
                  word_len++;
               end else begin
                  lex_mode = MODE_WORD_LONG;
               end
               return;
            end
         end
         MODE_WORD_LONG: if (is_letter(c) || is_digit(c)) return;
         MODE_NUM: begin
            if (is_digit(c)) begin
               if (num_digits < DIGIT_LIMIT) begin
                  num_value = num_value * 10 + (c - "0");
                  num_digits++;
               end else begin
                  num_digits = DIGIT_LIMIT + 1;
               end
               return;
            end
         end
         MODE_LT: begin
            if (c == CH_EQ || c == CH_GT) begin
               lex_mode = MODE_IDLE;
               push_token(c == CH_EQ ? TOK_LEQ : TOK_NEQ, ERR_NONE, '0, 8'h00, 1'b1);
               return;
            end
         end
         MODE_GT: begin
            if (c == CH_EQ || c == CH_LT) begin
               lex_mode = MODE_IDLE;
               push_token(c == CH_EQ ? TOK_GEQ : TOK_NEQ, ERR_NONE, '0, 8'h00, 1'b1);
               return;
            end
         end
         MODE_EQ: begin
            if (c == CH_EQ) begin
               lex_mode = MODE_IDLE;
               push_token(TOK_EQL, ERR_NONE, '0, 8'h00, 1'b1);
               return;
            end
         end
         MODE_COLON: begin
            if (c == CH_EQ) begin
               lex_mode = MODE_IDLE;
               push_token(TOK_BECOMES, ERR_NONE, '0, 8'h00, 1'b1);
               return;
            end
         end
         MODE_SLASH: begin
            if (c == CH_STAR) begin
               lex_mode = MODE_COMMENT;
               return;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_STAR) lex_mode = MODE_COMMENT_STAR;
            return;
         end
         MODE_COMMENT_STAR: begin
            if (c == CH_SLASH) lex_mode = MODE_IDLE;
            else if (c != CH_STAR) lex_mode = MODE_COMMENT;
            return;
         end
         default: ;
      endcase
      flush_pending();
      start_token(c);
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1) == 0) return 8'("a" + $urandom_range(25));
      return 8'("A" + $urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_alnum();
      if ($urandom_range(3) == 0) return 8'("0" + $urandom_range(9));
      return rand_letter();
   endfunction

   task automatic send_beat(input logic cmd, input logic [7:0] ch);
      req_type item;
      item.cmd = cmd;
      item.char_code = ch;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lex_beat(item);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(CMD_CHAR, s[i]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_token();
      int pick;
      int count;
      string word;
      logic [7:0] ch;
      bit nines;
      pick = $urandom_range(99);
      if (pick < 20) begin
         word = keywords[$urandom_range(13)];
         nines = ($urandom_range(5) == 0);
         for (int i = 0; i < word.len(); i++) begin
            ch = word[i];
            if (i == 0 && nines) ch = ch - 8'h20;
            send_beat(CMD_CHAR, ch);
         end
         if ($urandom_range(4) == 0) send_beat(CMD_CHAR, rand_alnum());
      end else if (pick < 40) begin
         count = ($urandom_range(4) == 0) ? $urandom_range(16, 12) : $urandom_range(IDENT_LIMIT, 1);
         send_beat(CMD_CHAR, rand_letter());
         for (int i = 1; i < count; i++) begin
            send_beat(CMD_CHAR, rand_alnum());
         end
      end else if (pick < 55) begin
         count = ($urandom_range(3) == 0) ? $urandom_range(8, 6) : $urandom_range(DIGIT_LIMIT, 1);
         nines = ($urandom_range(5) == 0);
         for (int i = 0; i < count; i++) begin
            send_beat(CMD_CHAR, nines ? 8'("9") : 8'("0" + $urandom_range(9)));
         end
      end else if (pick < 75) begin
         send_text(operators[$urandom_range(18)]);
      end else if (pick < 83) begin
         send_text("/*");
         count = $urandom_range(5);
         for (int i = 0; i < count; i++) begin
            send_beat(CMD_CHAR, comment_fill[$urandom_range(4)]);
         end
         if ($urandom_range(4) == 0) send_beat(CMD_END, 8'($urandom_range(255)));
         else send_text("*/");
      end else if (pick < 93) begin
         send_beat(CMD_CHAR, 8'($urandom_range(255)));
      end else begin
         send_beat(CMD_END, 8'($urandom_range(255)));
      end
      pick = $urandom_range(9);
      if (pick < 5) send_beat(CMD_CHAR, CH_SPACE);
      else if (pick == 5) send_beat(CMD_CHAR, 8'h0A);
      else if (pick == 6) send_beat(CMD_CHAR, 8'h09);
   endtask

   // Extreme bytes, a number running into a letter, a lone colon, a lone equals sign,
   // a comment whose opening star cannot close it, and flushes at end of text.
   task automatic test_edge_bytes();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_beat(CMD_CHAR, 8'h00);
      send_beat(CMD_CHAR, CH_DEL);
      send_beat(CMD_CHAR, 8'hFF);
      send_text("7q:;=/*/*/<");
      send_beat(CMD_END, 8'h00);
      send_text("/*");
      send_beat(CMD_END, 8'hFF);
      send_text("123456");
      send_beat(CMD_END, 8'h55);
      wait_drained();
   endtask

   task automatic test_random_tokens(input int idle_pct, input int stall_pct, input int beats);
      int target;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = beats_sent + beats;
      while (beats_sent < target) send_random_token();
      send_beat(CMD_END, 8'($urandom_range(255)));
      wait_drained();
   endtask

   // The receiver holds off long enough for identifier runs to back up into the input.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_request = 150;
      send_text("abcdefghijk alphabet42 zz9 ");
      send_beat(CMD_END, 8'h00);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (hold_off_request > 0) begin
         hold_off_left = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected beat class %0d error %0d value %0d char %02h last %0d",
                     $time, rsp_data.token_class, rsp_data.error_code,
                     rsp_data.number_value, rsp_data.text_char, rsp_data.last);
            failures++;
         end else begin
            want = pending_tokens.pop_front();
            tokens_checked++;
            if (rsp_data.token_class !== want.token_class ||
                rsp_data.error_code !== want.error_code ||
                rsp_data.number_value !== want.number_value ||
                rsp_data.text_char !== want.text_char ||
                rsp_data.last !== want.last) begin
               $display("%0t: mismatch, expected class %0d error %0d value %0d char %02h last %0d",
                        $time, want.token_class, want.error_code, want.number_value,
                        want.text_char, want.last);
               $display("%0t:           actual class %0d error %0d value %0d char %02h last %0d",
                        $time, rsp_data.token_class, rsp_data.error_code,
                        rsp_data.number_value, rsp_data.text_char, rsp_data.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, pending_tokens.size());
         $display("** pl0_lexical_tokenizer_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_bytes();
      test_random_tokens(0, 0, 50);
      test_random_tokens(66, 0, 50);
      test_random_tokens(0, 66, 50);
      test_random_tokens(9, 9, 50);
      test_back_pressure();
      wait_drained();
      $display("Sent %0d source beats and checked %0d result beats, %0d failures.",
               beats_sent, tokens_checked, failures);
      $display("Covered keywords, identifiers, numbers, operators, comments, bad bytes and ",
               "end-of-text flushes under four idling mixes and a long stall.");
      if (failures == 0) begin
         $display("** pl0_lexical_tokenizer_top: PASSED **");
      end else begin
         $display("** pl0_lexical_tokenizer_top: FAILED **");
      end
      $finish;
   end

endmodule
